/* rtl/core/drdf_pkg.sv */
`timescale 1ns / 1ps

package drdf_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int COORD_W     = 16;
   localparam int CLASS_W     = 7;
   localparam int THR_W       = 13;
   localparam int SCALE_W     = 16;
   localparam int POS_W       = 7;
   // 2*cx - w spans three times the sample range
   localparam int NUM_W       = SAMPLE_W + 2;
   localparam int PROD_W      = NUM_W + SCALE_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 96;

   localparam logic [POS_W-1:0] POS_LIMIT = 7'd127;
   localparam logic [POS_W-1:0] CLASS_CAP = 7'd122;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

   localparam logic [THR_W-1:0]   CONF_THR_RST  = 13'd1843;
   localparam logic [THR_W-1:0]   CLS_THR_RST   = 13'd2253;
   localparam logic [SCALE_W-1:0] SCALE_RST     = 16'd4096;
   localparam logic [CLASS_W-1:0] CLASS_CNT_RST = 7'd80;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONF_THR  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLS_THR   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_X_SCALE   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_Y_SCALE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLASS_CNT = 3'd4;

   typedef struct packed {
      logic [THR_W-1:0]   conf_thr;
      logic [THR_W-1:0]   cls_thr;
      logic [SCALE_W-1:0] x_scale;
      logic [SCALE_W-1:0] y_scale;
      logic [CLASS_W-1:0] class_count;
   } cfg_type;

   // Passing row, ready for scaling
   typedef struct packed {
      logic signed [NUM_W-1:0]    left_num;
      logic signed [NUM_W-1:0]    top_num;
      logic signed [SAMPLE_W-1:0] width;
      logic signed [SAMPLE_W-1:0] height;
      logic [CLASS_W-1:0]         class_index;
      logic signed [SAMPLE_W-1:0] objectness;
   } box_event_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] objectness;
      logic [CLASS_W-1:0]         class_index;
      logic signed [COORD_W-1:0]  box_height;
      logic signed [COORD_W-1:0]  box_width;
      logic signed [COORD_W-1:0]  box_top;
      logic signed [COORD_W-1:0]  box_left;
   } box_result_type;

endpackage

/* rtl/core/drdf_track.sv */
`timescale 1ns / 1ps

module drdf_track #(
   parameter int MAX_CLASSES = 80
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  drdf_pkg::cfg_type                     cfg,
   input  logic                                  in_valid,
   input  logic signed [drdf_pkg::SAMPLE_W-1:0]  in_value,
   input  logic                                  in_begin,
   output logic                                  in_ready,
   output logic                                  evt_valid,
   output drdf_pkg::box_event_type               evt,
   input  logic                                  evt_ready
);

   logic [drdf_pkg::POS_W-1:0]           pos_ff, pos_in, pos;
   logic signed [drdf_pkg::SAMPLE_W-1:0] cx_ff, cy_ff, w_ff, h_ff, obj_ff;
   logic signed [drdf_pkg::SAMPLE_W-1:0] best_ff, best_in;
   logic [drdf_pkg::CLASS_W-1:0]         best_cls_ff, best_cls_in;
   logic                                 evt_valid_ff;
   drdf_pkg::box_event_type              evt_ff, evt_in;
   logic [drdf_pkg::CLASS_W-1:0]         eff_cnt;
   logic [drdf_pkg::POS_W:0]             last_pos;
   logic                                 accept, in_scores, emit;

   assign in_ready = !evt_valid_ff || evt_ready;
   assign accept   = in_valid && in_ready;
   assign evt_valid = evt_valid_ff;
   assign evt       = evt_ff;

   always_comb begin
      eff_cnt = cfg.class_count;
      if (eff_cnt == '0) begin
         eff_cnt = drdf_pkg::CLASS_W'(1);
      end
      if ({1'b0, eff_cnt} > (drdf_pkg::CLASS_W + 1)'(MAX_CLASSES)) begin
         eff_cnt = drdf_pkg::CLASS_W'(MAX_CLASSES);
      end
      if (eff_cnt > drdf_pkg::CLASS_CAP) begin
         eff_cnt = drdf_pkg::CLASS_CAP;
      end
      last_pos = (drdf_pkg::POS_W + 1)'(4) + {1'b0, eff_cnt};

      pos       = in_begin ? '0 : pos_ff;
      pos_in    = (pos < drdf_pkg::POS_LIMIT) ? pos + 1'b1 : drdf_pkg::POS_LIMIT;
      in_scores = (pos >= drdf_pkg::POS_W'(5)) && ({1'b0, pos} <= last_pos);

      best_in     = best_ff;
      best_cls_in = best_cls_ff;
      if (pos == '0) begin
         best_in     = $signed(drdf_pkg::SAMPLE_MIN);
         best_cls_in = '0;
      end else if (in_scores && (in_value > best_ff)) begin
         best_in     = in_value;
         best_cls_in = pos - drdf_pkg::POS_W'(5);
      end

      emit = in_scores && ({1'b0, pos} == last_pos)
             && (obj_ff >= $signed({12'd0, cfg.conf_thr}))
             && (best_in >= $signed({12'd0, cfg.cls_thr}));

      evt_in.left_num    = (drdf_pkg::NUM_W'(cx_ff) <<< 1) - drdf_pkg::NUM_W'(w_ff);
      evt_in.top_num     = (drdf_pkg::NUM_W'(cy_ff) <<< 1) - drdf_pkg::NUM_W'(h_ff);
      evt_in.width       = w_ff;
      evt_in.height      = h_ff;
      evt_in.class_index = best_cls_in;
      evt_in.objectness  = obj_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         best_ff      <= $signed(drdf_pkg::SAMPLE_MIN);
         best_cls_ff  <= '0;
         evt_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff      <= pos_in;
            best_ff     <= best_in;
            best_cls_ff <= best_cls_in;
         end
         if (in_ready) begin
            evt_valid_ff <= accept && emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         unique case (pos)
            drdf_pkg::POS_W'(0): cx_ff  <= in_value;
            drdf_pkg::POS_W'(1): cy_ff  <= in_value;
            drdf_pkg::POS_W'(2): w_ff   <= in_value;
            drdf_pkg::POS_W'(3): h_ff   <= in_value;
            drdf_pkg::POS_W'(4): obj_ff <= in_value;
            default: ;
         endcase
      end
      if (accept && emit) begin
         evt_ff <= evt_in;
      end
   end

endmodule

/* rtl/core/drdf_scale.sv */
`timescale 1ns / 1ps

module drdf_scale #(
   parameter int FRACTION_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  drdf_pkg::cfg_type               cfg,
   input  logic                            evt_valid,
   input  drdf_pkg::box_event_type         evt,
   output logic                            evt_ready,
   output logic                            res_valid,
   output drdf_pkg::box_result_type        res,
   input  logic                            res_ready
);

   localparam int EDGE_SHIFT = 2 * FRACTION_BITS + 1;
   localparam int SIZE_SHIFT = 2 * FRACTION_BITS;
   localparam int PW         = drdf_pkg::PROD_W;

   logic                                  prod_valid_ff;
   logic signed [PW-1:0]                  pl_ff, pt_ff, pw_ff, ph_ff;
   logic [drdf_pkg::CLASS_W-1:0]          cls_ff;
   logic signed [drdf_pkg::SAMPLE_W-1:0]  obj_ff;
   logic signed [drdf_pkg::SCALE_W:0]     xs, ys;
   logic                                  take;

   // Divide by 2^shift rounding toward zero, then clamp to 16 bits
   function automatic logic signed [drdf_pkg::COORD_W-1:0] trunc_sat(
      input logic signed [PW-1:0] p,
      input int                   shift
   );
      logic signed [PW:0] biased, q;
      logic signed [PW:0] ones;
      ones   = ((PW + 1)'(1) <<< shift) - (PW + 1)'(1);
      biased = (PW + 1)'(p) + (p[PW-1] ? ones : '0);
      q      = biased >>> shift;
      if (q > (PW + 1)'(32767)) begin
         trunc_sat = 16'sh7FFF;
      end else if (q < -(PW + 1)'(32768)) begin
         trunc_sat = 16'sh8000;
      end else begin
         trunc_sat = q[drdf_pkg::COORD_W-1:0];
      end
   endfunction

   assign evt_ready = !prod_valid_ff || res_ready;
   assign take      = evt_valid && evt_ready;
   assign xs        = $signed({1'b0, cfg.x_scale});
   assign ys        = $signed({1'b0, cfg.y_scale});

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (evt_ready) begin
         prod_valid_ff <= evt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pl_ff  <= PW'(evt.left_num) * PW'(xs);
         pt_ff  <= PW'(evt.top_num) * PW'(ys);
         pw_ff  <= PW'(evt.width) * PW'(xs);
         ph_ff  <= PW'(evt.height) * PW'(ys);
         cls_ff <= evt.class_index;
         obj_ff <= evt.objectness;
      end
   end

   assign res_valid = prod_valid_ff;

   always_comb begin
      res.box_left    = trunc_sat(pl_ff, EDGE_SHIFT);
      res.box_top     = trunc_sat(pt_ff, EDGE_SHIFT);
      res.box_width   = trunc_sat(pw_ff, SIZE_SHIFT);
      res.box_height  = trunc_sat(ph_ff, SIZE_SHIFT);
      res.class_index = cls_ff;
      res.objectness  = obj_ff;
   end

endmodule

/* rtl/core/detection_row_decode_filter.sv */
`timescale 1ns / 1ps

// Detector output row decoder and filter.
// req_ carries one row element per transfer: center x, center y, width,
// height, objectness, then class_count class scores; req_tuser high marks
// center x and restarts the row. rsp_ carries one box per passing row:
// left, top, width, height in image pixels, the first best class and the
// objectness. Rows that miss either threshold give no transfer.
// csr_ writes the thresholds, scales and class count; write only while
// no row result is still in flight.
// Throughput: one element per cycle while req_tready is high. The box
// reaches rsp_ through the event register, the product register and the
// output register after the transfer of the row's last class score.
// Reset clears the row position, all valid flags and the registers to
// their defaults. When rsp_tready is low the output register holds the
// box; the earlier stages keep filling, and req_tready drops only once
// an event and a product wait behind a full output register.
module detection_row_decode_filter #(
   parameter int MAX_CLASSES   = 80,
   parameter int FRACTION_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [drdf_pkg::REQ_DATA_W-1:0]     req_tdata,  // sample_value
   input  logic                                req_tuser,  // row_begin
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // box_left, box_top, box_width, box_height, class_index, objectness, pad
   output logic [drdf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [drdf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [drdf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   drdf_pkg::cfg_type         cfg_ff;
   logic                      evt_valid, evt_ready, res_valid, res_ready;
   drdf_pkg::box_event_type   evt;
   drdf_pkg::box_result_type  res;
   logic                      rsp_valid_ff;
   drdf_pkg::box_result_type  rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conf_thr    <= drdf_pkg::CONF_THR_RST;
         cfg_ff.cls_thr     <= drdf_pkg::CLS_THR_RST;
         cfg_ff.x_scale     <= drdf_pkg::SCALE_RST;
         cfg_ff.y_scale     <= drdf_pkg::SCALE_RST;
         cfg_ff.class_count <= drdf_pkg::CLASS_CNT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            drdf_pkg::CSR_CONF_THR:  cfg_ff.conf_thr    <= csr_wdata[drdf_pkg::THR_W-1:0];
            drdf_pkg::CSR_CLS_THR:   cfg_ff.cls_thr     <= csr_wdata[drdf_pkg::THR_W-1:0];
            drdf_pkg::CSR_X_SCALE:   cfg_ff.x_scale     <= csr_wdata;
            drdf_pkg::CSR_Y_SCALE:   cfg_ff.y_scale     <= csr_wdata;
            drdf_pkg::CSR_CLASS_CNT: cfg_ff.class_count <= csr_wdata[drdf_pkg::CLASS_W-1:0];
            default: ;
         endcase
      end
   end

   drdf_track #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_value  ($signed(req_tdata)),
      .in_begin  (req_tuser),
      .in_ready  (req_tready),
      .evt_valid (evt_valid),
      .evt       (evt),
      .evt_ready (evt_ready)
   );

   drdf_scale #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .evt_valid (evt_valid),
      .evt       (evt),
      .evt_ready (evt_ready),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // A waiting event must not be replaced before the scaler takes it
   a_evt_hold: assert property (@(posedge clock) disable iff (reset)
      (evt_valid && !evt_ready) |=> (evt_valid && $stable(evt)))
      else $error("row event lost while scaler stalled");

   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_data_ff.class_index < drdf_pkg::CLASS_W'(MAX_CLASSES)))
      else $error("class index beyond class limit");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && !evt_valid))
      else $error("pipeline not empty after reset");

   a_no_input_while_full: assert property (@(posedge clock) disable iff (reset)
      (evt_valid && !evt_ready) |-> !req_tready)
      else $error("input taken while event register is blocked");

endmodule

/* tb/detection_row_decode_filter_tb.sv */
`timescale 1ns / 1ps

module detection_row_decode_filter_tb;
   import drdf_pkg::*;

   localparam int MAX_CLASSES   = 80;
   localparam int FRACTION_BITS = 12;
   localparam int BOX_W         = $bits(box_result_type);
   localparam int DRAIN_LIMIT   = 4000;

   typedef struct {
      logic [SAMPLE_W-1:0] value;
      logic                row_begin;
      bit                  has_box;
      box_result_type      box;
   } directed_item_t;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // predictor copy of the registers
   logic [THR_W-1:0]   conf_thr  = CONF_THR_RST;
   logic [THR_W-1:0]   cls_thr   = CLS_THR_RST;
   logic [SCALE_W-1:0] scale_x   = SCALE_RST;
   logic [SCALE_W-1:0] scale_y   = SCALE_RST;
   logic [CLASS_W-1:0] class_cnt = CLASS_CNT_RST;

   // predictor copy of the row state
   int                         row_pos     = 0;
   logic signed [SAMPLE_W-1:0] cx_hold     = '0;
   logic signed [SAMPLE_W-1:0] cy_hold     = '0;
   logic signed [SAMPLE_W-1:0] w_hold      = '0;
   logic signed [SAMPLE_W-1:0] h_hold      = '0;
   logic signed [SAMPLE_W-1:0] obj_hold    = '0;
   logic signed [SAMPLE_W-1:0] best_score  = SAMPLE_MIN;
   logic [CLASS_W-1:0]         best_class  = '0;

   box_result_type pending_boxes[$];
   directed_item_t directed_items[$];
   int             mismatch_count = 0;
   int             samples_sent   = 0;
   int             quiet_left     = 0;
   int             stall_left     = 0;

   detection_row_decode_filter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic note_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%t: %s", $realtime, msg);
   endtask

   // append one box to the tail of the expected queue
   task automatic expect_box(input box_result_type b);
      pending_boxes.insert(pending_boxes.size(), b);
   endtask

   function automatic int active_classes();
      int c;
      c = class_cnt;
      if (c == 0) c = 1;
      if (c > MAX_CLASSES) c = MAX_CLASSES;
      if (c > CLASS_CAP) c = CLASS_CAP;
      return c;
   endfunction

   // exact divide by 2^s toward zero, then clip to 16 bits
   function automatic logic [COORD_W-1:0] scale_clip(input longint p, input int s);
      longint q;
      q = (p < 0) ? -((-p) >>> s) : (p >>> s);
      if (q > 32767) q = 32767;
      else if (q < -32768) q = -32768;
      return q[COORD_W-1:0];
   endfunction

   function automatic box_result_type make_box(input int l, input int t, input int w,
                                               input int h, input int c, input int o);
      box_result_type b;
      b.box_left    = l[COORD_W-1:0];
      b.box_top     = t[COORD_W-1:0];
      b.box_width   = w[COORD_W-1:0];
      b.box_height  = h[COORD_W-1:0];
      b.class_index = c[CLASS_W-1:0];
      b.objectness  = o[SAMPLE_W-1:0];
      return b;
   endfunction

   function automatic void decode_sample(input logic signed [SAMPLE_W-1:0] v,
                                         input logic rb, output bit has_box,
                                         output box_result_type box);
      int     pos;
      int     last;
      longint lx;
      longint ty;
      pos = rb ? 0 : row_pos;
      last = 4 + active_classes();
      has_box = 1'b0;
      box = '0;
      if (pos == 0) begin
         cx_hold = v;
         best_score = SAMPLE_MIN;
         best_class = '0;
      end else if (pos == 1) begin
         cy_hold = v;
      end else if (pos == 2) begin
         w_hold = v;
      end else if (pos == 3) begin
         h_hold = v;
      end else if (pos == 4) begin
         obj_hold = v;
      end else if (pos <= last) begin
         // first maximum wins ties
         if (v > best_score) begin
            best_score = v;
            best_class = 7'(pos - 5);
         end
         if (pos == last && longint'(obj_hold) >= longint'(conf_thr) &&
             longint'(best_score) >= longint'(cls_thr)) begin
            lx = 2 * longint'(cx_hold) - longint'(w_hold);
            ty = 2 * longint'(cy_hold) - longint'(h_hold);
            box.box_left    = scale_clip(lx * longint'(scale_x), 2 * FRACTION_BITS + 1);
            box.box_top     = scale_clip(ty * longint'(scale_y), 2 * FRACTION_BITS + 1);
            box.box_width   = scale_clip(longint'(w_hold) * longint'(scale_x),
                                         2 * FRACTION_BITS);
            box.box_height  = scale_clip(longint'(h_hold) * longint'(scale_y),
                                         2 * FRACTION_BITS);
            box.class_index = best_class;
            box.objectness  = obj_hold;
            has_box = 1'b1;
         end
      end
      row_pos = (pos < POS_LIMIT) ? pos + 1 : POS_LIMIT;
   endfunction

   function automatic int idle_gap();
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         quiet_left = $urandom_range(20, 120);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   task automatic send_sample(input logic [SAMPLE_W-1:0] v, input logic rb);
      int gap;
      gap = idle_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tuser  <= rb;
      do @(posedge clock); while (!req_tready);
   endtask

   // transfer one element and queue whatever box the predictor expects
   task automatic feed(input logic [SAMPLE_W-1:0] v, input logic rb);
      bit             has_box;
      box_result_type box;
      if (rb || row_pos <= 4 + active_classes()) samples_sent++;
      send_sample(v, rb);
      decode_sample(v, rb, has_box, box);
      if (has_box) expect_box(box);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int val);
      logic [CSR_DATA_W-1:0] d;
      d = val[CSR_DATA_W-1:0];
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      case (idx)
         CSR_CONF_THR:  conf_thr  = d[THR_W-1:0];
         CSR_CLS_THR:   cls_thr   = d[THR_W-1:0];
         CSR_X_SCALE:   scale_x   = d[SCALE_W-1:0];
         CSR_Y_SCALE:   scale_y   = d[SCALE_W-1:0];
         CSR_CLASS_CNT: class_cnt = d[CLASS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_config(input int conf, input int cls, input int xs, input int ys,
                             input int cnt);
      write_reg(CSR_CONF_THR, conf);
      write_reg(CSR_CLS_THR, cls);
      write_reg(CSR_X_SCALE, xs);
      write_reg(CSR_Y_SCALE, ys);
      write_reg(CSR_CLASS_CNT, cnt);
      csr_wr_en <= 1'b0;
   endtask

   // idle the input, wait for every queued box, then let the pipeline settle
   task automatic drain_boxes();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_boxes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_boxes.size() != 0) begin
         note_error($sformatf("%0d expected boxes never arrived", pending_boxes.size()));
         mismatch_count += pending_boxes.size() - 1;
         pending_boxes.delete();
      end
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] near_value(input int t);
      if ($urandom_range(0, 99) < 75) return 24'(t + int'($urandom_range(0, 1000)) - 500);
      return 24'($urandom);
   endfunction

   function automatic logic [SAMPLE_W-1:0] box_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 24'($urandom_range(0, 2621440));
      if (r < 75) return 24'(-int'($urandom_range(0, 200000)));
      return 24'($urandom);
   endfunction

   task automatic send_row();
      int                  n;
      int                  len;
      int                  extra;
      int                  r;
      logic [SAMPLE_W-1:0] v;
      logic [SAMPLE_W-1:0] prev_score;
      n = 5 + active_classes();
      len = n;
      extra = 0;
      prev_score = '0;
      r = $urandom_range(0, 99);
      if (r < 7) len = $urandom_range(1, n - 1);
      else if (r < 13) extra = $urandom_range(1, 5);
      else if (r < 17) begin
         repeat ($urandom_range(1, 3)) feed(24'($urandom), 1'($urandom));
      end
      for (int i = 0; i < len; i++) begin
         if (i < 4) v = box_value();
         else if (i == 4) v = near_value(conf_thr);
         else if (i > 5 && $urandom_range(0, 99) < 15) v = prev_score;
         else v = near_value(cls_thr);
         if (i >= 5) prev_score = v;
         feed(v, i == 0);
      end
      // trailing elements past the row's end are ignored
      repeat (extra) feed(24'($urandom), 1'b0);
   endtask

   task automatic run_rows(input int budget);
      int stop_at;
      stop_at = samples_sent + budget;
      while (samples_sent < stop_at) send_row();
   endtask

   // append one row of the directed table
   task automatic add_step(input logic [SAMPLE_W-1:0] v, input logic rb, input bit hb,
                           input box_result_type b);
      directed_item_t item;
      item.value     = v;
      item.row_begin = rb;
      item.has_box   = hb;
      item.box       = b;
      directed_items.insert(directed_items.size(), item);
   endtask

   task automatic load_directed();
      box_result_type nb;
      nb = '0;
      // class count 2: cx, cy, w, h, obj, s0, s1; first row opens without row_begin
      add_step(24'd409600, 1'b0, 1'b0, nb);
      add_step(24'd819200, 1'b0, 1'b0, nb);
      add_step(24'd204800, 1'b0, 1'b0, nb);
      add_step(24'd245760, 1'b0, 1'b0, nb);
      add_step(24'd4096,   1'b0, 1'b0, nb);
      add_step(24'd3000,   1'b0, 1'b0, nb);
      // tied scores: class 0 wins
      add_step(24'd3000, 1'b0, 1'b1, make_box(75, 170, 50, 60, 0, 4096));
      add_step(24'd12345, 1'b0, 1'b0, nb);
      // objectness one below threshold
      add_step(24'd1, 1'b1, 1'b0, nb);
      add_step(24'd2, 1'b0, 1'b0, nb);
      add_step(24'd3, 1'b0, 1'b0, nb);
      add_step(24'd4, 1'b0, 1'b0, nb);
      add_step(24'd1842, 1'b0, 1'b0, nb);
      add_step(24'd4096, 1'b0, 1'b0, nb);
      add_step(24'd4096, 1'b0, 1'b0, nb);
      // extremes, both thresholds met exactly
      add_step(24'h800000, 1'b1, 1'b0, nb);
      add_step(24'h7fffff, 1'b0, 1'b0, nb);
      add_step(24'h7fffff, 1'b0, 1'b0, nb);
      add_step(24'h800000, 1'b0, 1'b0, nb);
      add_step(24'd1843, 1'b0, 1'b0, nb);
      add_step(24'h800000, 1'b0, 1'b0, nb);
      add_step(24'd2253, 1'b0, 1'b1, make_box(-3071, 3071, 2047, -2048, 1, 1843));
      // partial row, dropped by the next row_begin
      add_step(24'd5, 1'b1, 1'b0, nb);
      add_step(24'd6, 1'b0, 1'b0, nb);
   endtask

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got)
         note_error($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
   endtask

   always @(posedge clock) begin : box_monitor
      box_result_type got;
      box_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = box_result_type'(rsp_tdata[BOX_W-1:0]);
         if (pending_boxes.size() == 0) begin
            note_error($sformatf("unexpected box transfer 0x%h", rsp_tdata));
         end else begin
            want = pending_boxes.pop_front();
            check_field("box_left", want.box_left, got.box_left);
            check_field("box_top", want.box_top, got.box_top);
            check_field("box_width", want.box_width, got.box_width);
            check_field("box_height", want.box_height, got.box_height);
            check_field("class_index", want.class_index, got.class_index);
            check_field("objectness", want.objectness, got.objectness);
         end
      end
   end

   // output backpressure: mostly ready, short stalls, a few long ones
   always @(posedge clock) begin : sink_stall
      int r;
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp_tready <= 1'b1;
            stall_left <= $urandom_range(0, 15);
         end else if (r < 90) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(10, 40);
         end
      end
   end

   initial begin : stimulus
      bit             has_box;
      box_result_type box;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_config(CONF_THR_RST, CLS_THR_RST, SCALE_RST, SCALE_RST, 2);
      load_directed();
      foreach (directed_items[i]) begin
         send_sample(directed_items[i].value, directed_items[i].row_begin);
         decode_sample(directed_items[i].value, directed_items[i].row_begin, has_box, box);
         if (directed_items[i].has_box) expect_box(directed_items[i].box);
      end
      drain_boxes();

      set_config(CONF_THR_RST, CLS_THR_RST, SCALE_RST, SCALE_RST, CLASS_CNT_RST);
      run_rows(340);
      drain_boxes();
      // zero thresholds, full scales: large left and top values saturate
      set_config(0, 0, 65535, 65535, 1);
      run_rows(300);
      drain_boxes();
      // class count zero acts as one; thresholds at one
      set_config(4096, 4096, 0, 1, 0);
      run_rows(200);
      drain_boxes();
      // thresholds above one, class count above the maximum
      set_config(8191, 8191, 12345, 30000, 127);
      run_rows(260);
      drain_boxes();
      repeat (4) begin
         set_config($urandom_range(0, 4096), $urandom_range(0, 4096), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(1, 8));
         run_rows(200);
         drain_boxes();
      end

      if (mismatch_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
